// ===== rtl/core/cdq_pkg.sv =====
// Shared codes and constants for the circular double-ended queue.
package cdq_pkg;

  // Action codes carried on the request channel.
  typedef enum logic [1:0] {
    ACT_INS_FRONT = 2'd0,
    ACT_INS_REAR  = 2'd1,
    ACT_DEL_FRONT = 2'd2,
    ACT_DEL_REAR  = 2'd3
  } action_e;

  // Configuration register map, as word indices.
  localparam logic REG_CAPACITY = 1'b0;

  // Capacity register: width and value after reset.
  localparam int unsigned        CAP_W     = 11;
  localparam logic [CAP_W-1:0]   CAP_RESET = 11'd1024;

endpackage

// ===== rtl/core/circular_deque.sv =====
// Circular double-ended queue with its entries held in a single-port-read memory.
//
// Requests arrive on a valid/ready channel (in_valid_i, in_ready_o) and carry an
// action (insert front, insert rear, delete front, delete rear) and a data word.
// Every request gives exactly one response on the out channel: whether the action
// was done, the front and rear words afterwards (all ones when empty) and the
// empty and full flags. The capacity register, written over the APB port, sets how
// many ring slots are in use; writing it empties the queue.
//
// Inserts, refused actions and deletes of the last entry have their response
// formed as the request is taken and registered in the output register. A
// delete that leaves at least one entry must fetch the new end word from the
// slot memory, whose read data is registered, so its response is formed in the
// read state. The block takes one request every cycle unless that read state or
// a full holding register holds in_ready_o low; one request is in flight at a time.
// The response sits in an output register backed by a one-entry holding register,
// so a new request is taken while a finished response still waits. When the
// receiver stalls, the holding register fills and in_ready_o then drops.
// Reset empties the queue and restores the capacity; the memory is not cleared,
// as only slots holding live entries are ever read.
module circular_deque #(
  parameter int unsigned DEPTH      = 1024,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  // Request channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   action_i,
  input  logic signed [DATA_WIDTH-1:0] value_i,
  // Response channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         ok_o,
  output logic signed [DATA_WIDTH-1:0] front_value_o,
  output logic signed [DATA_WIDTH-1:0] rear_value_o,
  output logic                         is_empty_o,
  output logic                         is_full_o
);

  // Slot index width and entry count width.
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  // Effective capacity after reset: the reset capacity, limited to the memory depth.
  localparam int unsigned CAP_RST_EFF =
    (int'(cdq_pkg::CAP_RESET) > DEPTH) ? DEPTH : int'(cdq_pkg::CAP_RESET);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  typedef struct packed {
    logic                  ok;
    logic [DATA_WIDTH-1:0] front;
    logic [DATA_WIDTH-1:0] rear;
    logic                  empty;
    logic                  full;
  } resp_t;

  // Configuration state: the raw register and the capacity actually used.
  logic [cdq_pkg::CAP_W-1:0] capacity_q;
  logic [CW-1:0]             cap_q, cap_d;
  logic                      cfg_we;

  // Queue state.
  logic          state_q, state_d;
  logic [AW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CW-1:0] count_q, count_d;
  logic [DATA_WIDTH-1:0] front_q, front_d, rear_q, rear_d;
  logic          rd_front_q, rd_front_d;

  // Slot memory and its ports.
  logic [DATA_WIDTH-1:0] slot_mem_q [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_q;
  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_raddr;

  // Response path.
  resp_t resp, out_q, hold_q;
  logic  resp_valid, out_valid_q, hold_valid_q, out_free;

  logic          accept, is_ins, ins_ok, del_ok;
  logic [CW-1:0] head_ext, tail_ext, head_dec, head_inc, tail_dec, tail_inc;

  // ---------------------------------------------------------------------------
  // Configuration port. A write to the capacity register also empties the queue.
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == cdq_pkg::REG_CAPACITY);
  assign prdata = (paddr[2] == cdq_pkg::REG_CAPACITY) ? 32'(capacity_q) : 32'd0;

  // A capacity of zero acts as one; one above the memory depth acts as the depth.
  always_comb begin
    if (pwdata[cdq_pkg::CAP_W-1:0] == '0) begin
      cap_d = CW'(1);
    end else if (32'(pwdata[cdq_pkg::CAP_W-1:0]) > 32'(DEPTH)) begin
      cap_d = CW'(DEPTH);
    end else begin
      cap_d = CW'(pwdata[cdq_pkg::CAP_W-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= cdq_pkg::CAP_RESET;
      cap_q      <= CW'(CAP_RST_EFF);
    end else if (cfg_we) begin
      capacity_q <= pwdata[cdq_pkg::CAP_W-1:0];
      cap_q      <= cap_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Ring pointer arithmetic. Both pointers always stay below the capacity.
  // ---------------------------------------------------------------------------
  assign head_ext = CW'(head_q);
  assign tail_ext = CW'(tail_q);
  assign head_dec = (head_q == '0) ? cap_q - CW'(1) : head_ext - CW'(1);
  assign head_inc = (head_ext + CW'(1) >= cap_q) ? '0 : head_ext + CW'(1);
  assign tail_dec = (tail_q == '0) ? cap_q - CW'(1) : tail_ext - CW'(1);
  assign tail_inc = (tail_ext + CW'(1) >= cap_q) ? '0 : tail_ext + CW'(1);

  assign in_ready_o = (state_q == ST_IDLE) && !hold_valid_q;
  assign accept     = in_valid_i && in_ready_o;
  assign is_ins     = (action_i == cdq_pkg::ACT_INS_FRONT) ||
                      (action_i == cdq_pkg::ACT_INS_REAR);
  assign ins_ok     = count_q < cap_q;
  assign del_ok     = count_q != '0;

  // ---------------------------------------------------------------------------
  // Action sequencer. Inserts write one slot; a delete that leaves at least one
  // entry reads the slot that becomes the new end and finishes in the read state.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    front_d    = front_q;
    rear_d     = rear_q;
    rd_front_d = rd_front_q;
    mem_we     = 1'b0;
    mem_waddr  = head_q;
    mem_re     = 1'b0;
    mem_raddr  = head_q;
    resp_valid = 1'b0;
    resp.ok    = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          resp_valid = 1'b1;
          if (is_ins) begin
            if (ins_ok) begin
              resp.ok = 1'b1;
              count_d = count_q + CW'(1);
              mem_we  = 1'b1;
              if (count_q == '0) begin
                // First entry always lands in slot zero.
                head_d    = '0;
                tail_d    = '0;
                mem_waddr = '0;
                front_d   = value_i;
                rear_d    = value_i;
              end else if (action_i == cdq_pkg::ACT_INS_FRONT) begin
                head_d    = AW'(head_dec);
                mem_waddr = AW'(head_dec);
                front_d   = value_i;
              end else begin
                tail_d    = AW'(tail_inc);
                mem_waddr = AW'(tail_inc);
                rear_d    = value_i;
              end
            end
          end else if (del_ok) begin
            resp.ok = 1'b1;
            count_d = count_q - CW'(1);
            if (count_q == CW'(1)) begin
              head_d = '0;
              tail_d = '0;
            end else begin
              // New end word comes from memory; the response waits for it.
              resp_valid = 1'b0;
              mem_re     = 1'b1;
              state_d    = ST_READ;
              rd_front_d = (action_i == cdq_pkg::ACT_DEL_FRONT);
              if (action_i == cdq_pkg::ACT_DEL_FRONT) begin
                head_d    = AW'(head_inc);
                mem_raddr = AW'(head_inc);
              end else begin
                tail_d    = AW'(tail_dec);
                mem_raddr = AW'(tail_dec);
              end
            end
          end
        end
      end
      ST_READ: begin
        resp_valid = 1'b1;
        resp.ok    = 1'b1;
        state_d    = ST_IDLE;
        if (rd_front_q) begin
          front_d = rd_data_q;
        end else begin
          rear_d = rd_data_q;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Capacity write empties the queue; user must write only while idle (unchecked).
    if (cfg_we) begin
      head_d  = '0;
      tail_d  = '0;
      count_d = '0;
    end

    resp.empty = (count_d == '0);
    resp.full  = (count_d >= cap_q);
    resp.front = resp.empty ? '1 : front_d;
    resp.rear  = resp.empty ? '1 : rear_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      head_q     <= '0;
      tail_q     <= '0;
      count_q    <= '0;
      rd_front_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      count_q    <= count_d;
      rd_front_q <= rd_front_d;
    end
  end

  // End-word caches; only looked at while the queue is not empty.
  always_ff @(posedge clk_i) begin
    front_q <= front_d;
    rear_q  <= rear_d;
  end

  // Slot memory: one write port, one read port with registered data.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem_q[mem_waddr] <= value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd_data_q <= slot_mem_q[mem_raddr];
    end
  end

  // ---------------------------------------------------------------------------
  // Response register with a one-entry holding register behind it. A new
  // response never meets a full holding register, since requests stop while it
  // is occupied and only one request is in flight.
  // ---------------------------------------------------------------------------
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      hold_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= hold_valid_q || resp_valid;
      hold_valid_q <= 1'b0;
    end else if (resp_valid) begin
      hold_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= hold_valid_q ? hold_q : resp;
    end else if (resp_valid) begin
      hold_q <= resp;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign ok_o          = out_q.ok;
  assign front_value_o = out_q.front;
  assign rear_value_o  = out_q.rear;
  assign is_empty_o    = out_q.empty;
  assign is_full_o     = out_q.full;

endmodule

// ===== rtl/core/cdq_checker.sv =====
// Port-level assertions for the circular double-ended queue, bound to the top level.
module cdq_checker #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic                  ok_o,
  input logic [DATA_WIDTH-1:0] front_value_o,
  input logic [DATA_WIDTH-1:0] rear_value_o,
  input logic                  is_empty_o,
  input logic                  is_full_o
);

  // A stalled response keeps its ok flag, end words and empty flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(front_value_o) &&
      $stable(rear_value_o) && $stable(ok_o) && $stable(is_empty_o))
    else $error("response changed while stalled");

  // Capacity is at least one, so the queue cannot be both empty and full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(is_empty_o && is_full_o))
    else $error("empty and full reported together");

  // An empty queue reports all ones at both ends.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_empty_o |-> (front_value_o == '1) && (rear_value_o == '1))
    else $error("empty queue reports end words other than all ones");

  // A refused action is an insert into a full queue or a delete from an empty one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |-> is_empty_o || is_full_o)
    else $error("action refused while the queue was neither empty nor full");

  // A taken request is followed by out_valid_o, showing a presented response.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> ##[0:1] out_valid_o)
    else $error("no response presented after a request was taken");

endmodule

bind circular_deque cdq_checker #(.DATA_WIDTH(DATA_WIDTH)) u_cdq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .ok_o          (ok_o),
  .front_value_o (front_value_o),
  .rear_value_o  (rear_value_o),
  .is_empty_o    (is_empty_o),
  .is_full_o     (is_full_o)
);

// ===== tb/tb.sv =====
// Self-checking testbench for the circular double-ended queue.
`timescale 1ns / 1ps

module tb;

  // Ring size of the block as built, and the cycle budget for the whole run.
  localparam int SLOTS     = 1024;
  localparam int MAX_TICKS = 1000000;

  typedef struct packed {
    cdq_pkg::action_e act;
    logic [31:0]      word;
  } request_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] front;
    logic [31:0] rear;
    logic        empty;
    logic        full;
  } deque_resp_t;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [1:0]         action_i;
  logic signed [31:0] value_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               ok_o;
  logic signed [31:0] front_value_o;
  logic signed [31:0] rear_value_o;
  logic               is_empty_o;
  logic               is_full_o;

  circular_deque DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .ok_o          (ok_o),
    .front_value_o (front_value_o),
    .rear_value_o  (rear_value_o),
    .is_empty_o    (is_empty_o),
    .is_full_o     (is_full_o)
  );

  // Requests waiting to be presented, and the responses the shadow deque
  // has worked out for requests that the block has already taken.
  request_t    request_q[$];
  deque_resp_t outcome_q[$];

  // Shadow copy of the deque: ring contents, end pointers, fill level and
  // the raw capacity register as last written.
  logic [31:0]               shadow_ring [SLOTS];
  int                        shadow_head;
  int                        shadow_tail;
  int                        shadow_count;
  logic [cdq_pkg::CAP_W-1:0] shadow_cap;

  int  mismatches;
  int  ticks;
  bit  req_taken;
  int  in_gap;
  int  in_calm;
  int  out_stall;
  int  out_calm;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Capacity as the ring actually uses it: zero acts as one slot, anything
  // beyond the physical ring acts as the full ring.
  function automatic int ring_span();
    if (shadow_cap == '0) begin
      return 1;
    end
    if (int'(shadow_cap) > SLOTS) begin
      return SLOTS;
    end
    return int'(shadow_cap);
  endfunction

  // Applies one request to the shadow deque and returns the response the
  // block ought to give for it.
  function automatic deque_resp_t deque_apply(cdq_pkg::action_e act, logic [31:0] word);
    deque_resp_t r;
    int          span;
    span = ring_span();
    r.ok = 1'b0;
    if (act == cdq_pkg::ACT_INS_FRONT || act == cdq_pkg::ACT_INS_REAR) begin
      if (shadow_count < span) begin
        // The first entry always lands in slot zero, whichever end is named.
        if (shadow_count == 0) begin
          shadow_head    = 0;
          shadow_tail    = 0;
          shadow_ring[0] = word;
        end else if (act == cdq_pkg::ACT_INS_FRONT) begin
          shadow_head              = (shadow_head == 0) ? span - 1 : shadow_head - 1;
          shadow_ring[shadow_head] = word;
        end else begin
          shadow_tail              = (shadow_tail + 1 >= span) ? 0 : shadow_tail + 1;
          shadow_ring[shadow_tail] = word;
        end
        shadow_count++;
        r.ok = 1'b1;
      end
    end else if (shadow_count > 0) begin
      // Removing the last entry sends both pointers back to slot zero.
      if (shadow_count == 1) begin
        shadow_head = 0;
        shadow_tail = 0;
      end else if (act == cdq_pkg::ACT_DEL_FRONT) begin
        shadow_head = (shadow_head + 1 >= span) ? 0 : shadow_head + 1;
      end else begin
        shadow_tail = (shadow_tail == 0) ? span - 1 : shadow_tail - 1;
      end
      shadow_count--;
      r.ok = 1'b1;
    end
    // An empty deque shows all ones at both ends.
    r.front = (shadow_count == 0) ? '1 : shadow_ring[shadow_head];
    r.rear  = (shadow_count == 0) ? '1 : shadow_ring[shadow_tail];
    r.empty = (shadow_count == 0);
    r.full  = (shadow_count >= span);
    return r;
  endfunction

  // Data words lean towards the extremes now and then so that the sign bit,
  // all ones and all zeros turn up regularly.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 15))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // Idle stretches: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 88) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 25);
  endfunction

  task automatic queue_req(cdq_pkg::action_e act, logic [31:0] word);
    request_t req;
    req.act  = act;
    req.word = word;
    request_q.push_back(req);
  endtask

  // A random run of requests; ins_pct sets how often an insert is chosen,
  // which steers the fill level towards full or towards empty.
  task automatic queue_mix(int n, int ins_pct);
    bit ins;
    bit at_front;
    for (int i = 0; i < n; i++) begin
      ins      = ($urandom_range(0, 99) < ins_pct);
      at_front = $urandom_range(0, 1);
      if (ins) begin
        queue_req(at_front ? cdq_pkg::ACT_INS_FRONT : cdq_pkg::ACT_INS_REAR, pick_word());
      end else begin
        queue_req(at_front ? cdq_pkg::ACT_DEL_FRONT : cdq_pkg::ACT_DEL_REAR, pick_word());
      end
    end
  endtask

  // Waits until every queued request has been taken and answered, then lets the
  // clock run idle before returning so that nothing is left in flight.
  task automatic drain();
    while (request_q.size() != 0 || in_valid_i || outcome_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  // Two-phase register write. The shadow deque is emptied at the write edge,
  // just as the block empties itself when the capacity register is written.
  task automatic cap_write(logic [31:0] data);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {cdq_pkg::REG_CAPACITY, 2'b00};
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) begin
      @(posedge clk_i);
    end
    shadow_cap   = data[cdq_pkg::CAP_W-1:0];
    shadow_head  = 0;
    shadow_tail  = 0;
    shadow_count = 0;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Request driver. A request stays on the bus until it has been taken; after
  // that either an idle gap follows or the next request goes straight out.
  always @(negedge clk_i) begin : feed
    request_t req;
    if (in_calm > 0) begin
      in_calm <= in_calm - 1;
    end else if ($urandom_range(0, 39) == 0) begin
      in_calm <= $urandom_range(20, 100);
    end
    if (!in_valid_i || req_taken) begin
      if (in_gap > 0) begin
        in_valid_i <= 1'b0;
        in_gap     <= in_gap - 1;
      end else if (request_q.size() != 0) begin
        req = request_q.pop_front();
        in_valid_i <= 1'b1;
        action_i   <= req.act;
        value_i    <= req.word;
        in_gap     <= (in_calm > 0) ? 0 : pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Response side back-pressure, with calm stretches where every response is
  // taken at once.
  always @(negedge clk_i) begin
    if (out_calm > 0) begin
      out_calm <= out_calm - 1;
    end else if ($urandom_range(0, 39) == 0) begin
      out_calm <= $urandom_range(20, 100);
    end
    if (out_stall > 0) begin
      out_ready_i <= 1'b0;
      out_stall   <= out_stall - 1;
    end else begin
      out_ready_i <= 1'b1;
      out_stall   <= (out_calm > 0) ? 0 : pick_gap();
    end
  end

  // Monitor. A request taken at this edge is run through the shadow deque
  // first, then a response taken at this edge is checked against the oldest
  // prediction. Responses are registered, so none is presented at the edge that
  // takes its request, and the order within the edge cannot mislead.
  always @(posedge clk_i) begin : watch
    deque_resp_t want;
    req_taken <= in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o) begin
      outcome_q.push_back(deque_apply(cdq_pkg::action_e'(action_i), value_i));
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (outcome_q.size() == 0) begin
        $error("response with no request outstanding");
        mismatches++;
      end else begin
        want = outcome_q.pop_front();
        if (ok_o !== want.ok) begin
          $error("ok: expected %0b, got %0b", want.ok, ok_o);
          mismatches++;
        end
        if (front_value_o !== want.front) begin
          $error("front_value: expected %h, got %h", want.front, front_value_o);
          mismatches++;
        end
        if (rear_value_o !== want.rear) begin
          $error("rear_value: expected %h, got %h", want.rear, rear_value_o);
          mismatches++;
        end
        if (is_empty_o !== want.empty) begin
          $error("is_empty: expected %0b, got %0b", want.empty, is_empty_o);
          mismatches++;
        end
        if (is_full_o !== want.full) begin
          $error("is_full: expected %0b, got %0b", want.full, is_full_o);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    ticks <= ticks + 1;
    if (ticks >= MAX_TICKS) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    logic [31:0] caps [13];
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_valid_i   = 1'b0;
    action_i     = cdq_pkg::ACT_INS_FRONT;
    value_i      = '0;
    out_ready_i  = 1'b0;
    req_taken    = 1'b0;
    in_gap       = 0;
    in_calm      = 0;
    out_stall    = 0;
    out_calm     = 0;
    mismatches   = 0;
    ticks        = 0;
    shadow_cap   = cdq_pkg::CAP_RESET;
    shadow_head  = 0;
    shadow_tail  = 0;
    shadow_count = 0;

    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part at the reset capacity: deletes on an empty deque, inserts
    // into an empty deque from either end, extreme words, and removal of the
    // last entry from either end.
    queue_req(cdq_pkg::ACT_DEL_FRONT, 32'h1234_5678);
    queue_req(cdq_pkg::ACT_DEL_REAR,  32'h0000_0000);
    queue_req(cdq_pkg::ACT_INS_FRONT, 32'h7FFF_FFFF);
    queue_req(cdq_pkg::ACT_INS_FRONT, 32'h8000_0000);
    queue_req(cdq_pkg::ACT_INS_REAR,  32'h0000_0000);
    queue_req(cdq_pkg::ACT_INS_REAR,  32'hFFFF_FFFF);
    queue_req(cdq_pkg::ACT_INS_FRONT, 32'h0000_0001);
    queue_req(cdq_pkg::ACT_DEL_FRONT, 32'h0);
    queue_req(cdq_pkg::ACT_DEL_REAR,  32'h0);
    queue_req(cdq_pkg::ACT_DEL_FRONT, 32'h0);
    queue_req(cdq_pkg::ACT_DEL_REAR,  32'h0);
    queue_req(cdq_pkg::ACT_DEL_FRONT, 32'h0);
    queue_req(cdq_pkg::ACT_DEL_REAR,  32'h0);
    queue_req(cdq_pkg::ACT_INS_REAR,  32'hAAAA_5555);
    queue_req(cdq_pkg::ACT_DEL_REAR,  32'h0);
    drain();

    // A single slot: the second insert is refused as full. The deque is left
    // holding one entry so that the next write has something to discard.
    cap_write(32'd1);
    queue_req(cdq_pkg::ACT_INS_REAR,  32'h5555_AAAA);
    queue_req(cdq_pkg::ACT_INS_FRONT, 32'h0F0F_0F0F);
    queue_req(cdq_pkg::ACT_DEL_FRONT, 32'h0);
    queue_req(cdq_pkg::ACT_INS_FRONT, 32'hF0F0_F0F0);
    drain();

    // Capacity zero behaves as one slot, and the write has emptied the deque,
    // so the first delete is refused.
    cap_write(32'd0);
    queue_req(cdq_pkg::ACT_DEL_FRONT, 32'h0);
    queue_req(cdq_pkg::ACT_INS_FRONT, 32'h8000_0001);
    queue_req(cdq_pkg::ACT_INS_REAR,  32'h7FFF_FFFE);
    drain();

    // The largest register value clamps to the whole ring. Fill it completely
    // from random ends so that the head pointer wraps, overrun it twice, then mix.
    cap_write(32'd2047);
    for (int i = 0; i < SLOTS + 2; i++) begin
      queue_req($urandom_range(0, 1) ? cdq_pkg::ACT_INS_FRONT : cdq_pkg::ACT_INS_REAR,
                pick_word());
    end
    queue_mix(40, 50);
    drain();

    // Mostly small rings, where full and empty come round often.
    caps = '{32'd1, 32'd0, 32'd2, 32'd3, 32'd4, 32'd5, 32'd7, 32'd8, 32'd16,
             32'd1024, 32'd1500, 32'd0, 32'd0};
    caps[11] = $urandom_range(1, 40);
    // Stray bits above the register width must be dropped by the write.
    caps[12] = ($urandom() & 32'hFFFF_F800) | $urandom_range(1, 40);
    for (int p = 0; p < 13; p++) begin
      cap_write(caps[p]);
      queue_mix(65, (p % 2 == 0) ? 55 : 45);
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/cdq_pkg.sv
rtl/core/circular_deque.sv
rtl/core/cdq_checker.sv
tb/tb.sv
